### hdl/smpt_pkg.sv
// Shared types and codes for the shutter motor position tracker.
// No dependencies; every other file imports this package.
package smpt_pkg;

	// Field widths
	localparam int TIME_BITS = 20;
	localparam int CMD_W     = 3;
	localparam int DUR_W     = 10;
	localparam int POS_W     = 20;
	localparam int CFG_W     = 20;
	localparam int MS_PER_S  = 1000;
	localparam int PROD_W    = DUR_W + 10;

	// APB register map
	localparam int APB_AW    = 3;
	localparam int APB_DW    = 32;
	localparam logic [0:0] REG_CLOSE_TIME = 1'b0;
	localparam logic [CFG_W-1:0] CLOSE_TIME_RST = CFG_W'(30000);

	localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

	// Command codes
	localparam logic [CMD_W-1:0] CMD_TICK     = 3'd0;
	localparam logic [CMD_W-1:0] CMD_HOLD     = 3'd1;
	localparam logic [CMD_W-1:0] CMD_UP       = 3'd2;
	localparam logic [CMD_W-1:0] CMD_DOWN     = 3'd3;
	localparam logic [CMD_W-1:0] CMD_OPEN     = 3'd4;
	localparam logic [CMD_W-1:0] CMD_CLOSE    = 3'd5;
	localparam logic [CMD_W-1:0] CMD_POSITION = 3'd6;
	localparam logic [CMD_W-1:0] CMD_RESET    = 3'd7;

	// Motion state codes
	localparam logic [1:0] MS_STOPPED = 2'd0;
	localparam logic [1:0] MS_UP      = 2'd1;
	localparam logic [1:0] MS_DOWN    = 2'd2;

	// One result word
	typedef struct packed {
		logic             accepted;
		logic             relay_up;
		logic             relay_down;
		logic [POS_W-1:0] position_ms;
	} smpt_res_t;

	// Saturate a wide time value to the tracker width
	function automatic logic [TIME_BITS-1:0] sat_time(input logic [TIME_BITS+PROD_W-1:0] v);
		if (v > (TIME_BITS+PROD_W)'(TIME_MAX)) begin
			return TIME_MAX;
		end
		return v[TIME_BITS-1:0];
	endfunction

endpackage

### hdl/smpt_cmd_if.sv
// Command channel: valid/ready handshake carrying one command word.
// Depends on smpt_pkg for field widths.
interface smpt_cmd_if import smpt_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [CMD_W-1:0] cmd;
	logic [DUR_W-1:0] duration_s;

	modport source (output valid, cmd, duration_s, input ready);
	modport sink   (input valid, cmd, duration_s, output ready);
endinterface

### hdl/smpt_res_if.sv
// Result channel: valid/ready handshake carrying one result word.
// Depends on smpt_pkg for field widths.
interface smpt_res_if import smpt_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             accepted;
	logic             relay_up;
	logic             relay_down;
	logic [POS_W-1:0] position_ms;

	modport source (output valid, accepted, relay_up, relay_down, position_ms, input ready);
	modport sink   (input valid, accepted, relay_up, relay_down, position_ms, output ready);
endinterface

### hdl/smpt_regs.sv
// APB configuration register block: holds the full travel time.
// Depends on smpt_pkg for the register map.
module smpt_regs import smpt_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready,
	output logic [CFG_W-1:0]  close_time_ms
);

	logic             wr_en;
	logic [CFG_W-1:0] close_time_q;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_CLOSE_TIME);

	// Write the travel time register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			close_time_q <= CLOSE_TIME_RST;
		end else if (wr_en) begin
			close_time_q <= pwdata[CFG_W-1:0];
		end
	end

	// Read back; unmapped addresses read zero
	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_CLOSE_TIME) begin
			prdata = APB_DW'(close_time_q);
		end
	end

	assign close_time_ms = close_time_q;

endmodule

### hdl/smpt_core.sv
// Motion state, position and auto-stop countdown with their next-state logic.
// Depends on smpt_pkg for codes and the result word type.
module smpt_core import smpt_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  logic [CMD_W-1:0] cmd,
	input  logic [DUR_W-1:0] duration_s,
	input  logic [CFG_W-1:0] close_time_ms,
	output smpt_res_t        res
);

	logic [1:0]           motion_q;
	logic [TIME_BITS-1:0] pos_q;
	logic [TIME_BITS-1:0] count_q;

	logic [1:0]           motion_d;
	logic [TIME_BITS-1:0] pos_d;
	logic [TIME_BITS-1:0] count_d;
	logic                 ok;

	logic [TIME_BITS-1:0] limit;
	logic [TIME_BITS:0]   pos_inc;
	logic [TIME_BITS-1:0] count_dec;
	logic [PROD_W-1:0]    dur_ms;
	logic [TIME_BITS-1:0] close_rem;
	logic [TIME_BITS-1:0] move_len;
	logic [1:0]           move_dir;
	logic                 is_move;
	logic                 stopped;

	assign limit     = sat_time((TIME_BITS+PROD_W)'(close_time_ms));
	assign pos_inc   = {1'b0, pos_q} + 1'b1;
	assign count_dec = count_q - 1'b1;
	assign dur_ms    = PROD_W'(duration_s) * PROD_W'(MS_PER_S);
	assign stopped   = (motion_q == MS_STOPPED);

	// Remaining travel toward closed, zero when already past it
	always_comb begin
		close_rem = '0;
		if ((TIME_BITS+1)'(close_time_ms) > (TIME_BITS+1)'(pos_q)) begin
			close_rem = TIME_BITS'((TIME_BITS+1)'(close_time_ms) - (TIME_BITS+1)'(pos_q));
		end
	end

	// Decode the move direction and run length
	always_comb begin
		is_move  = 1'b0;
		move_dir = MS_STOPPED;
		move_len = '0;
		unique case (cmd)
			CMD_UP: begin
				is_move  = 1'b1;
				move_dir = MS_UP;
				move_len = sat_time((TIME_BITS+PROD_W)'(dur_ms));
			end
			CMD_DOWN: begin
				is_move  = 1'b1;
				move_dir = MS_DOWN;
				move_len = sat_time((TIME_BITS+PROD_W)'(dur_ms));
			end
			CMD_OPEN: begin
				is_move  = 1'b1;
				move_dir = MS_UP;
				move_len = pos_q;
			end
			CMD_CLOSE: begin
				is_move  = 1'b1;
				move_dir = MS_DOWN;
				move_len = close_rem;
			end
			CMD_RESET: begin
				is_move  = 1'b1;
				move_dir = MS_UP;
				move_len = sat_time((TIME_BITS+PROD_W)'(close_time_ms));
			end
			CMD_TICK, CMD_HOLD, CMD_POSITION: begin
				is_move = 1'b0;
			end
			default: begin
				is_move = 1'b0;
			end
		endcase
	end

	// Next state for one command
	always_comb begin
		motion_d = motion_q;
		pos_d    = pos_q;
		count_d  = count_q;
		ok       = 1'b1;
		if (cmd == CMD_TICK) begin
			// advance position, then run the auto-stop countdown
			if (motion_q == MS_UP) begin
				if (pos_q != '0) begin
					pos_d = pos_q - 1'b1;
				end
			end else if (motion_q == MS_DOWN) begin
				pos_d = (pos_inc > (TIME_BITS+1)'(limit)) ? limit : pos_inc[TIME_BITS-1:0];
			end
			if (count_q != '0) begin
				count_d = count_dec;
				if (count_dec == '0) begin
					motion_d = MS_STOPPED;
				end
			end
		end else if (cmd == CMD_HOLD) begin
			motion_d = MS_STOPPED;
			count_d  = '0;
		end else if (is_move) begin
			// moves only start from stopped
			if (stopped) begin
				motion_d = move_dir;
				count_d  = move_len;
			end else begin
				ok = 1'b0;
			end
		end
	end

	// Commit state when the word moves to the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			motion_q <= MS_STOPPED;
			pos_q    <= '0;
			count_q  <= '0;
		end else if (step) begin
			motion_q <= motion_d;
			pos_q    <= pos_d;
			count_q  <= count_d;
		end
	end

	assign res.accepted    = ok;
	assign res.relay_up    = (motion_d == MS_UP);
	assign res.relay_down  = (motion_d == MS_DOWN);
	assign res.position_ms = pos_d[POS_W-1:0];

endmodule

### hdl/shutter_motor_position_tracker.sv
// Top level of the shutter motor position tracker.
// Depends on smpt_pkg, smpt_cmd_if, smpt_res_if, smpt_regs and smpt_core.
//
// Usage:
//   cmd_in  : command words (cmd, duration_s); a tick word stands for 1 ms.
//   res_out : one result word per command (accepted, relay drives, position).
//   APB     : close_time_ms at byte address 0; pready is always high.
// Each accepted command goes into an input register; the state logic
// evaluates it there, and the result lands in the output register once
// that register is free or draining. One command is taken per cycle,
// sustained, while the receiver takes each result; the state update loop
// runs through the motion, position and countdown registers.
// While the receiver stalls, the result register holds its word and the
// input register holds the next one; cmd_in.ready drops only when both are
// full, and rises again in the cycle the receiver takes the result.
// Reset (arst_n low) stops the motor, clears position and countdown, sets
// close_time_ms to 30000 and empties both registers.
module shutter_motor_position_tracker import smpt_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	smpt_cmd_if.sink          cmd_in,
	smpt_res_if.source        res_out,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready
);

	logic             valid_s1;
	logic [CMD_W-1:0] cmd_s1;
	logic [DUR_W-1:0] dur_s1;
	logic             out_valid_q;
	smpt_res_t        res_q;
	smpt_res_t        res_d;
	logic             advance;
	logic [CFG_W-1:0] close_time_ms;

	smpt_regs u_regs (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.close_time_ms (close_time_ms)
	);

	smpt_core u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (advance),
		.cmd           (cmd_s1),
		.duration_s    (dur_s1),
		.close_time_ms (close_time_ms),
		.res           (res_d)
	);

	// Move the staged word on when the result register is free or draining
	assign advance      = valid_s1 && (!out_valid_q || res_out.ready);
	assign cmd_in.ready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd_in.ready) begin
			valid_s1 <= cmd_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_in.ready && cmd_in.valid) begin
			cmd_s1 <= cmd_in.cmd;
			dur_s1 <= cmd_in.duration_s;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (res_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_d;
		end
	end

	assign res_out.valid       = out_valid_q;
	assign res_out.accepted    = res_q.accepted;
	assign res_out.relay_up    = res_q.relay_up;
	assign res_out.relay_down  = res_q.relay_down;
	assign res_out.position_ms = res_q.position_ms;

endmodule
